// ===== hw/rtl/lar_pkg.sv =====
// ----------------------------------------------------------------------------
// lar_pkg
// Shared types and constants of the line assembler ring.
// ----------------------------------------------------------------------------
package lar_pkg;

  // Width of a stored line length; holds any line length up to 64.
  localparam int LEN_W = 7;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
  } lar_req_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       ring_empty;
    logic       last_char;
  } lar_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } lar_state_t;

endpackage

// ===== hw/rtl/line_assembler_ring_core.sv =====
// ----------------------------------------------------------------------------
// line_assembler_ring_core
// Assembles CR/LF-terminated lines into a ring of line slots and streams the
// oldest line back out on request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data): command 0 carries one
//   received byte, command 1 asks for the oldest stored line.
//   Response channel (rsp_valid/rsp_ready/rsp_data): one response per
//   character of the popped line, last_char set on the final one; a pop on
//   an empty ring gives one response with ring_empty and last_char set.
//   Byte requests produce nothing, so bytes stream in at one per cycle
//   while no pop response waits in the read stage. A pop answers with its
//   first character after the pop state, the store read and the output
//   register, and then one character per cycle while the receiver accepts;
//   the single read port of the character store sets that rate. A pop of L
//   characters keeps req_ready low until its last one has left the read stage.
//   A stalled receiver holds the output register and the read stage; the
//   store read is then not issued and the line counter waits.
//   Reset clears the ring pointers, the fill count and the pending flag;
//   the store and the length table need no clearing since a slot is only
//   read after it was written. The ring holds SLOTS-1 lines.
// ----------------------------------------------------------------------------
module line_assembler_ring_core
  import lar_pkg::*;
#(
  parameter int SLOTS       = 4,
  parameter int LINE_LENGTH = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  lar_req_t req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output lar_rsp_t rsp_data
);

  localparam int SW    = $clog2(SLOTS);
  localparam int IW    = $clog2(LINE_LENGTH);
  localparam int FW    = $clog2(LINE_LENGTH + 1);
  localparam int DEPTH = SLOTS * LINE_LENGTH;
  localparam int AW    = $clog2(DEPTH);

  // Ring and line assembly state.
  lar_state_t     state;
  logic [FW-1:0]  fill_index;
  logic [SW-1:0]  write_slot;
  logic [SW-1:0]  read_slot;
  logic           discarding;
  logic [IW-1:0]  pop_index;
  logic [LEN_W-1:0] line_len [SLOTS];

  // Read stage (store output) and output register.
  logic       rd_valid;
  logic       rd_last;
  logic       rd_empty;
  logic [7:0] mem_q;

  logic accept, is_byte, is_eol, ring_empty_now, ring_full;
  logic store_we, mem_re, move, rd_free, pop_last;
  logic [SW-1:0] write_slot_next, read_slot_next;
  logic [AW-1:0] waddr, raddr;
  logic [LEN_W-1:0] cur_len;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign req_ready = (state == ST_IDLE) && !rd_valid;
  assign accept    = req_valid && req_ready;
  assign is_byte   = (req_data.command == CMD_BYTE);
  assign is_eol    = (req_data.byte_value == CH_LF) || (req_data.byte_value == CH_CR);

  assign ring_empty_now  = (read_slot == write_slot);
  assign write_slot_next = slot_inc(write_slot);
  assign read_slot_next  = slot_inc(read_slot);
  assign ring_full       = (write_slot_next == read_slot);

  // Store a plain byte while the line has room and nothing is pending.
  assign store_we = accept && is_byte && !discarding && !is_eol
                    && (fill_index < FW'(LINE_LENGTH));
  assign waddr    = AW'(write_slot) * AW'(LINE_LENGTH) + AW'(fill_index);

  // Advance the read stage into the output register when it has room.
  assign move    = rd_valid && (!rsp_valid || rsp_ready);
  assign rd_free = !rd_valid || move;
  assign mem_re  = (state == ST_POP) && rd_free;
  assign raddr   = AW'(read_slot) * AW'(LINE_LENGTH) + AW'(pop_index);
  assign cur_len  = line_len[read_slot];
  assign pop_last = (LEN_W'(pop_index) + 1'b1 == cur_len);

  lar_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr),
    .wdata (req_data.byte_value),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (mem_q)
  );

  // Record the length of a line as it ends.
  always_ff @(posedge clk) begin
    if (accept && is_byte && !discarding && is_eol && (fill_index != '0)) begin
      line_len[write_slot] <= LEN_W'(fill_index);
    end
  end

  // Line assembly, ring pointers and pop sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_index <= '0;
      write_slot <= '0;
      read_slot  <= '0;
      discarding <= 1'b0;
      pop_index  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_byte) begin
              if (is_eol && (discarding || (fill_index != '0))) begin
                // Commit the line, or keep it pending while the ring is full.
                fill_index <= '0;
                discarding <= ring_full;
                if (!ring_full) begin
                  write_slot <= write_slot_next;
                end
              end else if (store_we) begin
                fill_index <= fill_index + 1'b1;
              end
            end else if (!ring_empty_now) begin
              state     <= ST_POP;
              pop_index <= '0;
            end
          end
        end
        ST_POP: begin
          if (mem_re) begin
            if (pop_last) begin
              read_slot <= read_slot_next;
              state     <= ST_IDLE;
            end else begin
              pop_index <= pop_index + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Read stage control: a store read or an empty report enters it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (mem_re || (accept && !is_byte && ring_empty_now)) begin
      rd_valid <= 1'b1;
    end else if (move) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_last  <= pop_last;
      rd_empty <= 1'b0;
    end else if (accept && !is_byte && ring_empty_now) begin
      rd_last  <= 1'b1;
      rd_empty <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      rsp_data.char_value <= rd_empty ? 8'h00 : mem_q;
      rsp_data.ring_empty <= rd_empty;
      rsp_data.last_char  <= rd_last;
    end
  end

  // Assertions.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_index <= FW'(LINE_LENGTH))
    else $error("fill count beyond line length");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> (read_slot != write_slot))
    else $error("streaming from an empty ring");

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_byte && ring_empty_now) |=> (rd_valid && rd_empty && rd_last))
    else $error("empty pop did not produce an empty report");

  a_no_req_while_pop: assert property (@(posedge clk) disable iff (rst)
    (mem_re && pop_last) |=> (state == ST_IDLE) && rd_valid && rd_last)
    else $error("last character not staged at end of pop");

endmodule

// ===== hw/rtl/lar_store.sv =====
// ----------------------------------------------------------------------------
// lar_store
// Character store of all line slots: one write port, one read port with
// enable and registered read data that holds while the enable is low.
// ----------------------------------------------------------------------------
module lar_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the last read value while the consumer stalls.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_assembler_ring_core. Streams received bytes
// and pop requests into the block, tracks the line ring in a scoreboard, and
// compares every streamed character, flag and empty report in order.
// ----------------------------------------------------------------------------
package line_ring_tb_pkg;
  import lar_pkg::*;

  localparam int RING_SLOTS = 4;
  localparam int SLOT_CHARS = 64;

  class line_ring_scoreboard;
    logic [7:0]       line_chars [RING_SLOTS][SLOT_CHARS];
    logic [LEN_W-1:0] line_len   [RING_SLOTS];
    int unsigned      fill_count;
    int unsigned      wr_slot;
    int unsigned      rd_slot;
    bit               line_pending;
    lar_rsp_t         expected_chars[$];
    int unsigned      mismatches;

    function new();
      fill_count   = 0;
      wr_slot      = 0;
      rd_slot      = 0;
      line_pending = 1'b0;
      mismatches   = 0;
    endfunction

    function int unsigned next_slot(int unsigned s);
      return (s + 1 >= RING_SLOTS) ? 0 : s + 1;
    endfunction

    // Close the line being built; hold it as pending when the ring is full.
    function void commit_line();
      int unsigned nxt;
      nxt          = next_slot(wr_slot);
      line_pending = 1'b0;
      if (nxt == rd_slot) line_pending = 1'b1;
      else wr_slot = nxt;
      fill_count = 0;
    endfunction

    function void note_request(lar_req_t r);
      bit          eol;
      int unsigned len;
      lar_rsp_t    rsp;
      eol = (r.byte_value == CH_LF) || (r.byte_value == CH_CR);
      if (r.command == CMD_BYTE) begin
        if (line_pending) begin
          if (eol) commit_line();
        end else if (eol) begin
          if (fill_count > 0) begin
            line_len[wr_slot] = fill_count[LEN_W-1:0];
            commit_line();
          end
        end else if (fill_count < SLOT_CHARS) begin
          line_chars[wr_slot][fill_count] = r.byte_value;
          fill_count++;
        end
      end else if (rd_slot == wr_slot) begin
        rsp.char_value = 8'h00;
        rsp.ring_empty = 1'b1;
        rsp.last_char  = 1'b1;
        expected_chars.push_back(rsp);
      end else begin
        len = 32'(line_len[rd_slot]);
        if (len > SLOT_CHARS) len = SLOT_CHARS;
        if (len == 0) len = 1;
        for (int unsigned i = 0; i < len; i++) begin
          rsp.char_value = line_chars[rd_slot][i];
          rsp.ring_empty = 1'b0;
          rsp.last_char  = (i + 1 == len);
          expected_chars.push_back(rsp);
        end
        rd_slot = next_slot(rd_slot);
      end
    endfunction

    function void check_response(lar_rsp_t got);
      lar_rsp_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected response: char_value %02h ring_empty %b last_char %b",
                 $time, got.char_value, got.ring_empty, got.last_char);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (got.char_value !== want.char_value) begin
        $display("%0t: char_value expected %02h got %02h",
                 $time, want.char_value, got.char_value);
        mismatches++;
      end
      if (got.ring_empty !== want.ring_empty) begin
        $display("%0t: ring_empty expected %b got %b",
                 $time, want.ring_empty, got.ring_empty);
        mismatches++;
      end
      if (got.last_char !== want.last_char) begin
        $display("%0t: last_char expected %b got %b",
                 $time, want.last_char, got.last_char);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_chars.size();
    endfunction
  endclass
endpackage

module tb_top;
  import lar_pkg::*;
  import line_ring_tb_pkg::*;

  localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all
  localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int RANDOM_ITEMS   = 12;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  lar_req_t req_data;
  logic     rsp_valid;
  logic     rsp_ready;
  lar_rsp_t rsp_data;

  line_ring_scoreboard book;

  bit          steady;        // both sides run without gaps while set
  bit          rx_hold;       // ask the receiver for one long hold-off
  int unsigned items_sent;
  int unsigned stalled_cycles;

  line_assembler_ring_core #(
    .SLOTS      (RING_SLOTS),
    .LINE_LENGTH(SLOT_CHARS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data (rsp_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length for either side: mostly none, often short, rarely long.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic lar_req_t make_byte(logic [7:0] b);
    lar_req_t r;
    r.command    = CMD_BYTE;
    r.byte_value = b;
    return r;
  endfunction

  // The byte field of a pop is ignored by the block; fill it with noise.
  function automatic lar_req_t make_pop();
    lar_req_t r;
    r.command    = CMD_POP;
    r.byte_value = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // Offer one request at a falling edge and hold it until the block takes it.
  // Valid stays high across back-to-back requests; it only drops for a gap or in wait_drained.
  task automatic send_request(lar_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req_data  = r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    book.note_request(r);
    items_sent++;
  endtask

  // Send n line characters, the terminator, and an optional trailing LF.
  task automatic send_line(int n, logic [7:0] term, bit crlf);
    for (int i = 0; i < n; i++) send_request(make_byte(line_byte()));
    send_request(make_byte(term));
    if (crlf) send_request(make_byte(CH_LF));
  endtask

  // Drop valid and hold off until every expected character has come back.
  task automatic wait_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  // Receiver: stall at random, or once on request for a long counted stretch.
  initial begin
    int stall;
    rsp_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        rsp_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        rsp_ready = 1'b0;
        stall = pick_gap();
        repeat (stall) @(negedge clk);
      end else begin
        rsp_ready = 1'b1;
      end
    end
  end

  // Check each accepted response against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) book.check_response(rsp_data);
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_start;
    int          pick;
    int          sz;
    int          r;
    book       = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_data   = '0;
    steady     = 1'b0;
    rx_hold    = 1'b0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty report, lone terminators, byte extremes, then fill the
    // ring, leave a line pending, retry while still full, and retry after a
    // pop frees a slot.
    send_request(make_pop());             // empty ring
    send_request(make_byte(CH_CR));       // terminator with nothing held
    send_request(make_byte(CH_LF));
    send_request(make_byte(8'h00));
    send_request(make_byte(8'hFF));
    send_request(make_byte(CH_CR));       // line one
    send_request(make_byte(8'h41));
    send_request(make_byte(CH_LF));       // line two, single character
    send_request(make_byte(8'h55));
    send_request(make_byte(8'hAA));
    send_request(make_byte(CH_CR));       // line three: ring now full
    send_request(make_byte(8'h31));
    send_request(make_byte(8'h32));
    send_request(make_byte(CH_CR));       // no free slot: line goes pending
    send_request(make_byte(8'h7E));       // dropped while pending
    send_request(make_byte(8'h80));
    send_request(make_byte(CH_LF));       // retry, still full
    send_request(make_pop());
    send_request(make_byte(8'h99));       // still dropped
    send_request(make_byte(CH_CR));       // retry succeeds
    repeat (4) send_request(make_pop());  // three lines, then empty again
    wait_drained();

    // Pressure: store an over-long line, then pop it while the receiver holds
    // off, and keep offering bytes so the block backs up into the request
    // channel.
    send_line(66, CH_CR, 1'b0);
    rx_hold = 1'b1;
    send_request(make_pop());
    send_line(5, CH_LF, 1'b0);
    send_request(make_pop());
    wait_drained();

    // Random: mostly whole lines with random content, mixed with pops, pop
    // bursts and raw bytes that may cut a line short.
    random_start = items_sent;
    steady       = 1'b1;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent - random_start > 3) steady = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        r = $urandom_range(0, 99);
        if (r < 85)      sz = $urandom_range(1, 8);
        else if (r < 95) sz = $urandom_range(9, 40);
        else             sz = $urandom_range(60, 70);
        send_line(sz, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF,
                  $urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        send_request(make_pop());
      end else if (pick < 90) begin
        repeat ($urandom_range(2, 4)) send_request(make_pop());
      end else begin
        send_request(make_byte(8'($urandom_range(0, 255))));
      end
      // Pause near the middle of the run until every character is back.
      if (items_sent - random_start >= RANDOM_ITEMS / 2 &&
          items_sent - random_start < RANDOM_ITEMS / 2 + 4) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (book.mismatches == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lar_pkg.sv
hw/rtl/lar_store.sv
hw/rtl/line_assembler_ring_core.sv
tb/tb_top.sv
